// ===== src/zeis_pkg.sv =====
// Shared types, constants and width helpers for the zone edge intensity sums block.
`timescale 1ns / 1ps

package zeis_pkg;

    localparam int MAX_ZONE_SIZE_DEF = 64;
    localparam int REG_W             = 7;
    localparam int REG_MAX           = 127;
    localparam int PIX_W             = 8;
    localparam int LEVEL_W           = 10;
    localparam int LEVEL_SCALE       = 1000;
    localparam int FULL_INTENSITY    = 255;
    localparam int QUOT_BITS         = 10;
    localparam int STEP_W            = $clog2(QUOT_BITS);
    localparam int LANES             = 5;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [REG_W-1:0] WIDTH_RST  = 7'd8;
    localparam logic [REG_W-1:0] HEIGHT_RST = 7'd16;

    localparam int LANE_LEFT   = 0;
    localparam int LANE_RIGHT  = 1;
    localparam int LANE_TOP    = 2;
    localparam int LANE_BOTTOM = 3;
    localparam int LANE_CENTER = 4;

    typedef enum logic [0:0] {
        CFG_ZONE_WIDTH  = 1'b0,
        CFG_ZONE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_back_state;

    // Largest zone side that a 7-bit register can select under the given maximum.
    function automatic int eff_max(input int max_size);
        eff_max = (max_size < REG_MAX) ? max_size : REG_MAX;
    endfunction

    function automatic int size_w(input int max_size);
        size_w = $clog2(eff_max(max_size) + 1);
    endfunction

    function automatic int cnt_w(input int max_size);
        cnt_w = $clog2(eff_max(max_size));
    endfunction

    function automatic int sum_w(input int max_size);
        sum_w = $clog2(eff_max(max_size) * eff_max(max_size) * FULL_INTENSITY + 1);
    endfunction

endpackage

// ===== src/zeis_front.sv =====
// Front part: configuration registers, pixel position counters and the five strip sums.
`timescale 1ns / 1ps

module zeis_front
    import zeis_pkg::*;
#(
    parameter int MAX_ZONE_SIZE = MAX_ZONE_SIZE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic                                          i_cfg_index,
    input  logic [REG_W-1:0]                              i_cfg_wdata,
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  logic [PIX_W-1:0]                              i_pixel_red,
    input  logic                                          i_q_full,
    output logic                                          o_q_push,
    output logic [LANES-1:0][sum_w(MAX_ZONE_SIZE)-1:0]    o_q_sums,
    output logic [sum_w(MAX_ZONE_SIZE)-1:0]               o_q_full_scale
);

    localparam int EFF_MAX = eff_max(MAX_ZONE_SIZE);
    localparam int SIZE_W  = size_w(MAX_ZONE_SIZE);
    localparam int CNT_W   = cnt_w(MAX_ZONE_SIZE);
    localparam int SUM_W   = sum_w(MAX_ZONE_SIZE);

    logic [REG_W-1:0]                r_zone_width;
    logic [REG_W-1:0]                r_zone_height;
    logic [CNT_W-1:0]                r_col;
    logic [CNT_W-1:0]                r_row;
    logic [LANES-1:0][SUM_W-1:0]     r_sum;

    logic [CNT_W-1:0]                n_col;
    logic [CNT_W-1:0]                n_row;
    logic [LANES-1:0][SUM_W-1:0]     n_sum;
    logic [LANES-1:0][SUM_W-1:0]     add_sum;
    logic [LANES-1:0]                hit;

    logic [SIZE_W-1:0]               w;
    logic [SIZE_W-1:0]               h;
    logic [SIZE_W-1:0]               lb;
    logic [SIZE_W-1:0]               rb;
    logic [SIZE_W-1:0]               tb;
    logic [SIZE_W-1:0]               bb;
    logic [SIZE_W-1:0]               x;
    logic [SIZE_W-1:0]               y;
    logic [2*SIZE_W-1:0]             wh;
    logic                            accept;
    logic                            row_end;
    logic                            zone_end;

    always_comb begin
        priority if (r_zone_width == '0) begin
            w = SIZE_W'(1);
        end else if (32'(r_zone_width) > 32'(EFF_MAX)) begin
            w = SIZE_W'(EFF_MAX);
        end else begin
            w = SIZE_W'(r_zone_width);
        end
        priority if (r_zone_height == '0) begin
            h = SIZE_W'(1);
        end else if (32'(r_zone_height) > 32'(EFF_MAX)) begin
            h = SIZE_W'(EFF_MAX);
        end else begin
            h = SIZE_W'(r_zone_height);
        end

        lb = w >> 2;
        rb = w - lb;
        tb = h >> 2;
        bb = h - tb;
        x  = SIZE_W'(r_col);
        y  = SIZE_W'(r_row);

        hit[LANE_LEFT]   = (x <= lb);
        hit[LANE_RIGHT]  = (x >= rb);
        hit[LANE_TOP]    = (y <= tb);
        hit[LANE_BOTTOM] = (y >= bb);
        hit[LANE_CENTER] = (x >= lb) && (x <= rb) && (y >= tb) && (y <= bb);

        for (int k = 0; k < LANES; k++) begin
            add_sum[k] = hit[k] ? (r_sum[k] + SUM_W'(i_pixel_red)) : r_sum[k];
        end

        row_end  = ((x + SIZE_W'(1)) >= w);
        zone_end = row_end && ((y + SIZE_W'(1)) >= h);

        n_col = row_end ? '0 : (r_col + CNT_W'(1));
        if (!row_end) begin
            n_row = r_row;
        end else if (zone_end) begin
            n_row = '0;
        end else begin
            n_row = r_row + CNT_W'(1);
        end
        n_sum = zone_end ? '0 : add_sum;

        wh = w * h;
    end

    assign o_in_stall     = i_q_full;
    assign accept         = i_in_valid && !i_q_full;
    assign o_q_push       = accept && zone_end;
    assign o_q_sums       = add_sum;
    assign o_q_full_scale = SUM_W'({wh, 8'b0}) - SUM_W'(wh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_width  <= WIDTH_RST;
            r_zone_height <= HEIGHT_RST;
            r_col         <= '0;
            r_row         <= '0;
            r_sum         <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ZONE_WIDTH:  r_zone_width  <= i_cfg_wdata;
                CFG_ZONE_HEIGHT: r_zone_height <= i_cfg_wdata;
                default:         r_zone_width  <= r_zone_width;
            endcase
            r_col <= '0;
            r_row <= '0;
            r_sum <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_sum <= n_sum;
        end
    end

endmodule

// ===== src/zeis_queue.sv =====
// Short request queue holding finished zone sums between the front and back parts.
`timescale 1ns / 1ps

module zeis_queue
    import zeis_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;

    assign o_full  = (r_count == COUNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : (r_wr_ptr + PTR_W'(1));
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : (r_rd_ptr + PTR_W'(1));
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - COUNT_W'(1);
            end
        end
    end

endmodule

// ===== src/zeis_back.sv =====
// Back part: five-lane restoring divider that scales the zone sums to per-mille levels.
`timescale 1ns / 1ps

module zeis_back
    import zeis_pkg::*;
#(
    parameter int MAX_ZONE_SIZE = MAX_ZONE_SIZE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_q_valid,
    input  logic [LANES-1:0][sum_w(MAX_ZONE_SIZE)-1:0]    i_q_sums,
    input  logic [sum_w(MAX_ZONE_SIZE)-1:0]               i_q_full_scale,
    output logic                                          o_q_pop,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output logic [LANES-1:0][LEVEL_W-1:0]                 o_levels
);

    localparam int SUM_W = sum_w(MAX_ZONE_SIZE);
    localparam int NUM_W = SUM_W + QUOT_BITS;

    t_back_state                    r_state;
    t_back_state                    n_state;
    logic [LANES-1:0][NUM_W-1:0]    r_rem;
    logic [NUM_W-1:0]               r_dsh;
    logic [STEP_W-1:0]              r_step;
    logic [LANES-1:0][LEVEL_W-1:0]  r_quo;
    logic [LANES-1:0][LEVEL_W-1:0]  r_level;
    logic                           r_out_valid;
    logic                           load_out;
    logic [LANES-1:0]               ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            ge[k] = (r_rem[k] >= r_dsh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= NUM_W'(i_q_sums[k]) * NUM_W'(LEVEL_SCALE);
            end
            r_dsh  <= NUM_W'(i_q_full_scale) << (QUOT_BITS - 1);
            r_step <= STEP_W'(QUOT_BITS - 1);
        end else if (r_state == S_DIV) begin
            for (int k = 0; k < LANES; k++) begin
                if (ge[k]) begin
                    r_rem[k] <= r_rem[k] - r_dsh;
                end
                r_quo[k] <= {r_quo[k][LEVEL_W-2:0], ge[k]};
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - STEP_W'(1);
        end
        if (load_out) begin
            r_level <= r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_levels    = r_level;

`ifndef SYNTHESIS
    for (genvar k = 0; k < LANES; k++) begin : g_chk
        a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_out_valid |-> (r_level[k] <= LEVEL_W'(LEVEL_SCALE)))
            else $error("Level above full scale on lane %0d.", k);
        a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DIV) |-> ({1'b0, r_rem[k]} < {r_dsh, 1'b0}))
            else $error("Divider remainder out of range on lane %0d.", k);
    end
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("Queue popped while empty.");
`endif

endmodule

// ===== src/zone_edge_intensity_sums_top.sv =====
// Top level of the zone edge intensity sums block.
`timescale 1ns / 1ps

// Pixels of a zone are taken in raster order at one per cycle unless the input stalls.
// When a zone's last pixel is accepted, its five sums enter a two-entry queue and the
// front starts the next zone at once. A five-lane restoring divider takes one zone from
// the queue, multiplies its sums by 1000 as it loads them, works out ten quotient bits
// and then hands the levels to the output register; it takes the next zone only after
// that. The input stalls only while both queue entries hold finished zones, which can
// happen with zones that are finished faster than the divider empties the queue, or a
// stalled output. Writing either size register restarts the current zone.
module zone_edge_intensity_sums_top
    import zeis_pkg::*;
#(
    parameter int MAX_ZONE_SIZE = MAX_ZONE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [REG_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PIX_W-1:0]   i_pixel_red,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LEVEL_W-1:0] o_left_level,
    output logic [LEVEL_W-1:0] o_right_level,
    output logic [LEVEL_W-1:0] o_top_level,
    output logic [LEVEL_W-1:0] o_bottom_level,
    output logic [LEVEL_W-1:0] o_center_level
);

    localparam int SUM_W = sum_w(MAX_ZONE_SIZE);
    localparam int Q_W   = (LANES + 1) * SUM_W;

    logic                           q_push;
    logic                           q_full;
    logic                           q_valid;
    logic                           q_pop;
    logic [LANES-1:0][SUM_W-1:0]    push_sums;
    logic [SUM_W-1:0]               push_full_scale;
    logic [LANES-1:0][SUM_W-1:0]    pop_sums;
    logic [SUM_W-1:0]               pop_full_scale;
    logic [Q_W-1:0]                 pop_data;
    logic [LANES-1:0][LEVEL_W-1:0]  levels;

    zeis_front #(
        .MAX_ZONE_SIZE(MAX_ZONE_SIZE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_red    (i_pixel_red),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_sums       (push_sums),
        .o_q_full_scale (push_full_scale)
    );

    zeis_queue #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data ({push_full_scale, push_sums}),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_data      (pop_data)
    );

    assign pop_sums       = pop_data[LANES*SUM_W-1:0];
    assign pop_full_scale = pop_data[Q_W-1:LANES*SUM_W];

    zeis_back #(
        .MAX_ZONE_SIZE(MAX_ZONE_SIZE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_sums       (pop_sums),
        .i_q_full_scale (pop_full_scale),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_levels       (levels)
    );

    assign o_left_level   = levels[LANE_LEFT];
    assign o_right_level  = levels[LANE_RIGHT];
    assign o_top_level    = levels[LANE_TOP];
    assign o_bottom_level = levels[LANE_BOTTOM];
    assign o_center_level = levels[LANE_CENTER];

endmodule

// ===== dv/tb_zone_edge_intensity_sums_top.sv =====
// Self-checking testbench for zone_edge_intensity_sums_top with its own zone sums predictor.
`timescale 1ns / 1ps

module tb_zone_edge_intensity_sums_top;
    import zeis_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [LEVEL_W-1:0] left_lvl;
        logic [LEVEL_W-1:0] right_lvl;
        logic [LEVEL_W-1:0] top_lvl;
        logic [LEVEL_W-1:0] bottom_lvl;
        logic [LEVEL_W-1:0] center_lvl;
    } t_zone_levels;

    class t_zone_sums_board;
        int unsigned  width_reg;
        int unsigned  height_reg;
        int unsigned  col;
        int unsigned  row;
        int unsigned  sum_left;
        int unsigned  sum_right;
        int unsigned  sum_top;
        int unsigned  sum_bottom;
        int unsigned  sum_center;
        t_zone_levels expected_levels[$];
        int unsigned  fail_count;
        int unsigned  checked_count;

        function new();
            width_reg     = WIDTH_RST;
            height_reg    = HEIGHT_RST;
            fail_count    = 0;
            checked_count = 0;
            clear_zone();
        endfunction

        function void clear_zone();
            col        = 0;
            row        = 0;
            sum_left   = 0;
            sum_right  = 0;
            sum_top    = 0;
            sum_bottom = 0;
            sum_center = 0;
        endfunction

        function int unsigned eff_size(input int unsigned reg_value);
            if (reg_value == 0) begin
                return 1;
            end
            if (reg_value > MAX_ZONE_SIZE_DEF) begin
                return MAX_ZONE_SIZE_DEF;
            end
            return reg_value;
        endfunction

        function void write_reg(input t_cfg_index idx, input logic [REG_W-1:0] value);
            if (idx == CFG_ZONE_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
            clear_zone();
        endfunction

        function logic [LEVEL_W-1:0] to_level(input int unsigned sum,
                                              input longint unsigned full);
            longint unsigned scaled;
            scaled = (longint'(sum) * LEVEL_SCALE) / full;
            if (scaled > LEVEL_SCALE) begin
                scaled = LEVEL_SCALE;
            end
            return scaled[LEVEL_W-1:0];
        endfunction

        function void note_pixel(input logic [PIX_W-1:0] px);
            int unsigned     w;
            int unsigned     h;
            int unsigned     lb;
            int unsigned     rb;
            int unsigned     tb;
            int unsigned     bb;
            longint unsigned full;
            t_zone_levels    lv;
            w  = eff_size(width_reg);
            h  = eff_size(height_reg);
            lb = w / 4;
            rb = w - lb;
            tb = h / 4;
            bb = h - tb;
            if (col <= lb) sum_left += px;
            if (col >= rb) sum_right += px;
            if (row <= tb) sum_top += px;
            if (row >= bb) sum_bottom += px;
            if (col >= lb && col <= rb && row >= tb && row <= bb) sum_center += px;
            if (col + 1 < w) begin
                col++;
                return;
            end
            col = 0;
            if (row + 1 < h) begin
                row++;
                return;
            end
            full          = longint'(w) * h * FULL_INTENSITY;
            lv.left_lvl   = to_level(sum_left, full);
            lv.right_lvl  = to_level(sum_right, full);
            lv.top_lvl    = to_level(sum_top, full);
            lv.bottom_lvl = to_level(sum_bottom, full);
            lv.center_lvl = to_level(sum_center, full);
            expected_levels.push_back(lv);
            clear_zone();
        endfunction

        task report_mismatch(input string what, input int unsigned got,
                             input int unsigned want);
            $display("ERROR: %0t %s got %0d expected %0d", $realtime, what, got, want);
            fail_count++;
        endtask

        task check_result(input t_zone_levels got);
            t_zone_levels want;
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected result, left level", got.left_lvl, 0);
                return;
            end
            want = expected_levels.pop_front();
            checked_count++;
            if (got.left_lvl != want.left_lvl)
                report_mismatch("left level", got.left_lvl, want.left_lvl);
            if (got.right_lvl != want.right_lvl)
                report_mismatch("right level", got.right_lvl, want.right_lvl);
            if (got.top_lvl != want.top_lvl)
                report_mismatch("top level", got.top_lvl, want.top_lvl);
            if (got.bottom_lvl != want.bottom_lvl)
                report_mismatch("bottom level", got.bottom_lvl, want.bottom_lvl);
            if (got.center_lvl != want.center_lvl)
                report_mismatch("center level", got.center_lvl, want.center_lvl);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [REG_W-1:0]   i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [PIX_W-1:0]   i_pixel_red;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [LEVEL_W-1:0] o_left_level;
    logic [LEVEL_W-1:0] o_right_level;
    logic [LEVEL_W-1:0] o_top_level;
    logic [LEVEL_W-1:0] o_bottom_level;
    logic [LEVEL_W-1:0] o_center_level;

    t_zone_sums_board sb = new();
    int unsigned    gap_pct      = 0;
    int unsigned    stall_pct    = 0;
    int unsigned    pixels_sent  = 0;
    int unsigned    cycle_count  = 0;
    int unsigned    phase_no     = 0;

    zone_edge_intensity_sums_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_red    (i_pixel_red),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_level   (o_left_level),
        .o_right_level  (o_right_level),
        .o_top_level    (o_top_level),
        .o_bottom_level (o_bottom_level),
        .o_center_level (o_center_level)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && !i_out_stall) begin
            sb.check_result({o_left_level, o_right_level, o_top_level,
                             o_bottom_level, o_center_level});
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(7))
            0: return '1;
            1: return '0;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 46; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 46; end
            default: begin gap_pct = 8; stall_pct = 8; end
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pixel_red <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_levels.size() != 0);
    endtask

    task automatic settle_block();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_zone(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ZONE_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        sb.write_reg(CFG_ZONE_WIDTH, w);
        i_cfg_index <= CFG_ZONE_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        sb.write_reg(CFG_ZONE_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_zones(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                             input int unsigned zones);
        int unsigned n;
        set_idling(phase_no);
        phase_no++;
        set_zone(w, h);
        n = sb.eff_size(w) * sb.eff_size(h);
        repeat (zones) begin
            repeat (n) send_pixel(random_pixel());
            if ($urandom_range(7) == 0) wait_results();
        end
        if (n > 1 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, n - 1)) send_pixel(random_pixel());
        end
    endtask

    initial begin
        logic [REG_W-1:0] w;
        logic [REG_W-1:0] h;
        logic [REG_W-1:0] t;
        int unsigned      zones;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ZONE_WIDTH;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_pixel_red <= '0;
        i_out_stall <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset sizes give one full zone before any register is written.
        repeat (sb.eff_size(WIDTH_RST) * sb.eff_size(HEIGHT_RST)) send_pixel(random_pixel());

        set_zone(0, 0);
        send_pixel('0);
        send_pixel('1);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        set_zone(2, 2);
        repeat (3) send_pixel('1);
        set_zone(2, 2);
        repeat (4) send_pixel('1);
        set_zone(3, 3);
        repeat (9) send_pixel('1);

        run_zones(127, 1, 1);
        run_zones(1, 127, 1);
        run_zones(64, 2, 1);
        run_zones(65, 3, 1);
        run_zones(0, 64, 1);
        run_zones(3, 0, 2);

        while (pixels_sent < 1600) begin
            if ($urandom_range(9) == 0) begin
                w     = REG_W'($urandom_range(0, 127));
                h     = REG_W'($urandom_range(0, 4));
                zones = 1;
                if ($urandom_range(1)) begin
                    t = w;
                    w = h;
                    h = t;
                end
            end else begin
                w     = REG_W'($urandom_range(0, 12));
                h     = REG_W'($urandom_range(0, 12));
                zones = $urandom_range(1, 4);
            end
            run_zones(w, h, zones);
        end

        settle_block();
        if (sb.fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
